// ===== rtl/mdsp_pkg.sv =====
// ============================================================================
// mdsp_pkg
// Shared types, constants and the CRC-32/MPEG-2 byte update for the MPE
// datagram section parser.
// ============================================================================
package mdsp_pkg;

    // Field masks and header layout.
    localparam logic [7:0]  SYNTAX_MASK       = 8'h80;
    localparam logic [7:0]  LENGTH_HIGH_MASK  = 8'h0f;
    localparam logic [11:0] MIN_SECTION_LEN   = 12'd13;
    localparam logic [12:0] LENGTH_FIELD_END  = 13'd3;
    localparam logic [13:0] TRAILER_BYTES     = 14'd4;
    localparam logic [12:0] LAST_HEADER_POS   = 13'd2;
    localparam logic [31:0] CRC_POLY          = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT          = 32'hffffffff;

    // Header byte positions within a section.
    localparam logic [12:0] POS_TID        = 13'd0;
    localparam logic [12:0] POS_LEN_HIGH   = 13'd1;
    localparam logic [12:0] POS_LEN_LOW    = 13'd2;
    localparam logic [12:0] POS_MAC6       = 13'd3;
    localparam logic [12:0] POS_MAC5       = 13'd4;
    localparam logic [12:0] POS_FLAGS      = 13'd5;
    localparam logic [12:0] POS_SECTION    = 13'd6;
    localparam logic [12:0] POS_LAST_SEC   = 13'd7;
    localparam logic [12:0] POS_MAC4       = 13'd8;
    localparam logic [12:0] POS_MAC3       = 13'd9;
    localparam logic [12:0] POS_MAC2       = 13'd10;
    localparam logic [12:0] POS_MAC1       = 13'd11;

    // Configuration register byte addresses.
    localparam logic [1:0] ADDR_CTRL = 2'd0;

    typedef enum logic [1:0] {
        STATUS_CRC_GOOD     = 2'd0,
        STATUS_CRC_BAD      = 2'd1,
        STATUS_CHECKSUM     = 2'd2,
        STATUS_LENGTH_ERROR = 2'd3
    } status_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        section_done;
        logic [7:0]  section_tid;
        logic [47:0] mac_address;
        logic        snap_encap;
        logic [1:0]  payload_scrambling;
        logic [1:0]  address_scrambling;
        logic        current_next;
        logic [7:0]  section_index;
        logic [7:0]  last_section_index;
        status_t     check_status;
    } mdsp_result_t;

    // One byte of CRC-32/MPEG-2, MSB first, no reflection.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            if (c[31])
            begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/mdsp_cfg_regs.sv =====
// ============================================================================
// mdsp_cfg_regs
// APB-style configuration register holding the CRC check enable.
// ============================================================================
module mdsp_cfg_regs
    import mdsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        crc_check_enable
);

    logic crc_en_reg;
    logic crc_en_next;

    always_comb
    begin
        crc_en_next = crc_en_reg;
        if (psel && penable && pwrite && (paddr == ADDR_CTRL))
        begin
            crc_en_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg <= 1'b1;
        end
        else
        begin
            crc_en_reg <= crc_en_next;
        end
    end

    assign prdata           = (paddr == ADDR_CTRL) ? {31'd0, crc_en_reg} : 32'd0;
    assign pready           = 1'b1;
    assign crc_check_enable = crc_en_reg;

endmodule

// ===== rtl/mdsp_parser.sv =====
// ============================================================================
// mdsp_parser
// Section state and per-byte decode: header capture, CRC, trailer check.
// ============================================================================
module mdsp_parser
    import mdsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic [7:0]   in_byte,
    input  logic         in_start,
    input  logic         crc_check_enable,
    output mdsp_result_t result
);

    logic [12:0] pos_reg,     pos_next;
    logic [11:0] len_reg,     len_next;
    logic [7:0]  tid_reg,     tid_next;
    logic        syntax_reg,  syntax_next;
    logic [5:0]  flags_reg,   flags_next;
    logic [47:0] mac_reg,     mac_next;
    logic [15:0] secnum_reg,  secnum_next;
    logic [31:0] crc_reg,     crc_next;
    logic [31:0] trailer_reg, trailer_next;
    logic        active_reg,  active_next;

    logic [12:0] pos_cur;
    logic [12:0] total;
    logic        in_body;
    logic        last_byte;
    logic [11:0] len_low;
    logic [7:0]  len_high;

    assign pos_cur   = in_start ? 13'd0 : pos_reg;
    assign total     = {1'b0, (in_start ? 12'd0 : len_reg)} + LENGTH_FIELD_END;
    assign in_body   = ({1'b0, pos_cur} + TRAILER_BYTES) < {1'b0, total};
    assign last_byte = ({1'b0, pos_cur} + 14'd1) >= {1'b0, total};
    assign len_low   = {len_reg[11:8], in_byte};
    assign len_high  = in_byte & LENGTH_HIGH_MASK;

    always_comb
    begin
        pos_next     = pos_reg;
        len_next     = len_reg;
        tid_next     = tid_reg;
        syntax_next  = syntax_reg;
        flags_next   = flags_reg;
        mac_next     = mac_reg;
        secnum_next  = secnum_reg;
        crc_next     = crc_reg;
        trailer_next = trailer_reg;
        active_next  = active_reg;
        result       = '0;

        if (advance)
        begin
            // A start flag abandons any running section.
            if (in_start)
            begin
                len_next     = 12'd0;
                tid_next     = 8'd0;
                syntax_next  = 1'b0;
                flags_next   = 6'd0;
                mac_next     = 48'd0;
                secnum_next  = 16'd0;
                crc_next     = CRC_INIT;
                trailer_next = 32'd0;
                active_next  = 1'b1;
            end

            if (in_start || active_reg)
            begin
                if ((pos_cur <= LAST_HEADER_POS) || in_body)
                begin
                    crc_next = crc32_byte(crc_next, in_byte);
                end

                case (pos_cur)
                    POS_TID: tid_next = in_byte;
                    POS_LEN_HIGH:
                    begin
                        syntax_next = |(in_byte & SYNTAX_MASK);
                        len_next    = {len_high[3:0], 8'h00};
                    end
                    POS_LEN_LOW:
                    begin
                        len_next = len_low;
                        if (len_low < MIN_SECTION_LEN)
                        begin
                            result.section_done = 1'b1;
                            result.check_status = STATUS_LENGTH_ERROR;
                            active_next         = 1'b0;
                        end
                    end
                    POS_MAC6:     mac_next[7:0]     = in_byte;
                    POS_MAC5:     mac_next[15:8]    = in_byte;
                    POS_FLAGS:    flags_next        = in_byte[5:0];
                    POS_SECTION:  secnum_next[15:8] = in_byte;
                    POS_LAST_SEC: secnum_next[7:0]  = in_byte;
                    POS_MAC4:     mac_next[23:16]   = in_byte;
                    POS_MAC3:     mac_next[31:24]   = in_byte;
                    POS_MAC2:     mac_next[39:32]   = in_byte;
                    POS_MAC1:     mac_next[47:40]   = in_byte;
                    default:
                    begin
                        if (in_body)
                        begin
                            result.data_valid = 1'b1;
                            result.data_byte  = in_byte;
                        end
                        else
                        begin
                            trailer_next = {trailer_next[23:0], in_byte};
                            if (last_byte)
                            begin
                                result.section_done = 1'b1;
                                active_next         = 1'b0;
                                if (!syntax_next)
                                begin
                                    result.check_status = STATUS_CHECKSUM;
                                end
                                else if (!crc_check_enable || (crc_next == trailer_next))
                                begin
                                    result.check_status = STATUS_CRC_GOOD;
                                end
                                else
                                begin
                                    result.check_status = STATUS_CRC_BAD;
                                end
                            end
                        end
                    end
                endcase

                pos_next = pos_cur + 13'd1;
            end
        end

        result.section_tid        = tid_next;
        result.mac_address        = mac_next;
        result.snap_encap         = flags_next[1];
        result.payload_scrambling = flags_next[5:4];
        result.address_scrambling = flags_next[3:2];
        result.current_next       = flags_next[0];
        result.section_index      = secnum_next[15:8];
        result.last_section_index = secnum_next[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 13'd0;
            len_reg     <= 12'd0;
            tid_reg     <= 8'd0;
            syntax_reg  <= 1'b0;
            flags_reg   <= 6'd0;
            mac_reg     <= 48'd0;
            secnum_reg  <= 16'd0;
            crc_reg     <= CRC_INIT;
            trailer_reg <= 32'd0;
            active_reg  <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            tid_reg     <= tid_next;
            syntax_reg  <= syntax_next;
            flags_reg   <= flags_next;
            mac_reg     <= mac_next;
            secnum_reg  <= secnum_next;
            crc_reg     <= crc_next;
            trailer_reg <= trailer_next;
            active_reg  <= active_next;
        end
    end

endmodule

// ===== rtl/mpe_datagram_section_parser.sv =====
// ============================================================================
// mpe_datagram_section_parser
// Byte-serial parser for MPE datagram sections with header unpacking,
// payload extraction and CRC-32/MPEG-2 trailer check.
// ============================================================================
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+--------------------------------------
//  byte in   | byte_valid / byte_stall   | section_byte, section_start
//  result    | result_valid/result_stall | data_valid .. check_status
//  config    | APB (psel, penable, ...)  | paddr, pwdata, prdata
//
// One section byte is taken per clock while byte_stall is low. A transfer
// on the byte channel lands in the input register; when that byte advances,
// the parser updates its section state and the result register together.
// The byte-wise CRC update and position compare set the combinational path.
// Reset clears all section state and sets the CRC check enable. A stalled
// result holds in the result register while one more byte is taken into
// the input register; only then does byte_stall rise.
//
module mpe_datagram_section_parser
    import mdsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Byte channel.
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  section_byte,
    input  logic        section_start,
    // Result channel.
    output logic        result_valid,
    input  logic        result_stall,
    output logic        data_valid,
    output logic [7:0]  data_byte,
    output logic        section_done,
    output logic [7:0]  section_tid,
    output logic [47:0] mac_address,
    output logic        snap_encap,
    output logic [1:0]  payload_scrambling,
    output logic [1:0]  address_scrambling,
    output logic        current_next,
    output logic [7:0]  section_index,
    output logic [7:0]  last_section_index,
    output logic [1:0]  check_status,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic         crc_check_enable;

    // Input register.
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_start_reg;

    // Result register.
    logic         out_valid_reg;
    logic         out_valid_next;
    mdsp_result_t out_result_reg;
    mdsp_result_t parse_result;

    logic         byte_take;
    logic         advance;

    mdsp_cfg_regs u_cfg_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .crc_check_enable (crc_check_enable)
    );

    // The held byte moves on whenever the result register is free or being drained.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign byte_take  = byte_valid && !byte_stall;

    mdsp_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .in_byte          (in_byte_reg),
        .in_start         (in_start_reg),
        .crc_check_enable (crc_check_enable),
        .result           (parse_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            in_byte_reg  <= section_byte;
            in_start_reg <= section_start;
        end
        if (advance)
        begin
            out_result_reg <= parse_result;
        end
    end

    assign result_valid       = out_valid_reg;
    assign data_valid         = out_result_reg.data_valid;
    assign data_byte          = out_result_reg.data_byte;
    assign section_done       = out_result_reg.section_done;
    assign section_tid        = out_result_reg.section_tid;
    assign mac_address        = out_result_reg.mac_address;
    assign snap_encap         = out_result_reg.snap_encap;
    assign payload_scrambling = out_result_reg.payload_scrambling;
    assign address_scrambling = out_result_reg.address_scrambling;
    assign current_next       = out_result_reg.current_next;
    assign section_index      = out_result_reg.section_index;
    assign last_section_index = out_result_reg.last_section_index;
    assign check_status       = out_result_reg.check_status;

endmodule

// ===== rtl/mdsp_checker.sv =====
// ============================================================================
// mdsp_checker
// Port-level assertions for the MPE datagram section parser.
// ============================================================================
module mdsp_checker
    import mdsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic        data_valid,
    input logic [7:0]  data_byte,
    input logic        section_done,
    input logic [1:0]  check_status,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [1:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // A status is only reported when a section closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !section_done) |-> (check_status == STATUS_CRC_GOOD))
        else $error("check status set without section end");

    // A payload byte never coincides with the end of a section.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && data_valid) |-> !section_done)
        else $error("payload byte flagged as section end");

    // Non-payload results carry a zero data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !data_valid) |-> (data_byte == 8'd0))
        else $error("data byte nonzero without data valid");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(data_byte)
            && $stable(section_done) && $stable(check_status)))
        else $error("stalled result changed");

    // A control register write reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr == ADDR_CTRL))
            |=> ((paddr != ADDR_CTRL) || (prdata[0] == $past(pwdata[0]))))
        else $error("control register readback mismatch");

endmodule

bind mpe_datagram_section_parser mdsp_checker u_mdsp_checker (.*);

// ===== tb/mpe_datagram_section_parser_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mpe_datagram_section_parser_tb
// Self-checking bench for the MPE datagram section parser. Section bytes are
// streamed in through a clocked driver with random gaps. A built-in parser
// model predicts every result, and a clocked monitor applies random
// backpressure and compares each result transfer field by field.
// ============================================================================
module mpe_datagram_section_parser_tb;
    import mdsp_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    // Input register plus result register, with some margin.
    localparam int SETTLE_CYCLES  = 8;
    // Longest legal quiet stretch is a long sender gap meeting a long
    // receiver stall.
    localparam int WATCHDOG_LIMIT = 4000;

    // One entry of the stimulus queue: a section byte and its start flag.
    typedef struct packed {
        logic [7:0] value;
        logic       first;
    } byte_item_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        byte_valid    = 1'b0;
    logic [7:0]  section_byte  = 8'h00;
    logic        section_start = 1'b0;
    logic        result_stall  = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [1:0]  paddr         = ADDR_CTRL;
    logic [31:0] pwdata        = 32'h0;

    logic        byte_stall;
    logic        result_valid;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        section_done;
    logic [7:0]  section_tid;
    logic [47:0] mac_address;
    logic        snap_encap;
    logic [1:0]  payload_scrambling;
    logic [1:0]  address_scrambling;
    logic        current_next;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    logic [1:0]  check_status;
    logic [31:0] prdata;
    logic        pready;

    always #(CLK_PERIOD / 2) clk = ~clk;

    mpe_datagram_section_parser dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .byte_valid         (byte_valid),
        .byte_stall         (byte_stall),
        .section_byte       (section_byte),
        .section_start      (section_start),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .data_valid         (data_valid),
        .data_byte          (data_byte),
        .section_done       (section_done),
        .section_tid        (section_tid),
        .mac_address        (mac_address),
        .snap_encap         (snap_encap),
        .payload_scrambling (payload_scrambling),
        .address_scrambling (address_scrambling),
        .current_next       (current_next),
        .section_index      (section_index),
        .last_section_index (last_section_index),
        .check_status       (check_status),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // ------------------------------------------------------------------
    // Bench bookkeeping.
    // ------------------------------------------------------------------
    byte_item_t   pending_bytes[$];     // bytes waiting to be driven
    mdsp_result_t expected_results[$];  // predicted results, oldest first
    byte_item_t   next_item;
    int           errors       = 0;
    int           gap_left     = 0;
    int           stall_left   = 0;
    int           stall_draw   = 0;
    int           calm_bytes   = 0;
    int           calm_results = 0;
    int           idle_cycles  = 0;

    // ------------------------------------------------------------------
    // Parser model state. It mirrors what the block keeps per section,
    // plus the bench's copy of the CRC check enable register.
    // ------------------------------------------------------------------
    logic        crc_enable  = 1'b1;
    logic [12:0] sec_pos     = '0;
    logic [11:0] sec_len     = '0;
    logic [7:0]  hdr_table   = '0;
    logic        hdr_syntax  = 1'b0;
    logic [5:0]  hdr_flags   = '0;
    logic [47:0] hdr_mac     = '0;
    logic [15:0] hdr_numbers = '0;
    logic [31:0] run_crc     = CRC_INIT;
    logic [31:0] trl_word    = '0;
    logic        in_section  = 1'b0;

    // CRC-32/MPEG-2 advanced by one byte, taking the data bits MSB first.
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        feedback;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = c[31] ^ b[i];
            c = {c[30:0], 1'b0};
            if (feedback)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Advances the parser model by one accepted byte and returns the
    // result that the block must give for it.
    function automatic mdsp_result_t parse_byte(input logic [7:0] b, input logic first);
        mdsp_result_t r;
        logic [12:0]  p;
        logic [13:0]  total;
        logic [13:0]  trail_mark;
        r = '0;
        r.check_status = STATUS_CRC_GOOD;
        if (first)
        begin
            // A start always opens a fresh section; a running one is dropped
            // without any status.
            sec_pos     = '0;
            sec_len     = '0;
            hdr_table   = '0;
            hdr_syntax  = 1'b0;
            hdr_flags   = '0;
            hdr_mac     = '0;
            hdr_numbers = '0;
            run_crc     = CRC_INIT;
            trl_word    = '0;
            in_section  = 1'b1;
        end
        if (in_section)
        begin
            p          = sec_pos;
            total      = {2'b00, sec_len} + 14'd3;
            trail_mark = {1'b0, p} + TRAILER_BYTES;
            // Until the length is known every byte is covered by the CRC;
            // afterwards only bytes ahead of the trailer are.
            if (p < LENGTH_FIELD_END || trail_mark < total)
            begin
                run_crc = crc_step(run_crc, b);
            end
            case (p)
                POS_TID: hdr_table = b;
                POS_LEN_HIGH:
                begin
                    hdr_syntax = b[7];
                    sec_len    = {b[3:0], 8'h00};
                end
                POS_LEN_LOW:
                begin
                    sec_len = sec_len | {4'h0, b};
                    if (sec_len < MIN_SECTION_LEN)
                    begin
                        r.section_done = 1'b1;
                        r.check_status = STATUS_LENGTH_ERROR;
                        in_section     = 1'b0;
                    end
                end
                POS_MAC6:     hdr_mac[7:0]       = b;
                POS_MAC5:     hdr_mac[15:8]      = b;
                POS_FLAGS:    hdr_flags          = b[5:0];
                POS_SECTION:  hdr_numbers[15:8]  = b;
                POS_LAST_SEC: hdr_numbers[7:0]   = b;
                POS_MAC4:     hdr_mac[23:16]     = b;
                POS_MAC3:     hdr_mac[31:24]     = b;
                POS_MAC2:     hdr_mac[39:32]     = b;
                POS_MAC1:     hdr_mac[47:40]     = b;
                default:
                begin
                    if (trail_mark < total)
                    begin
                        r.data_valid = 1'b1;
                        r.data_byte  = b;
                    end
                    else
                    begin
                        trl_word = {trl_word[23:0], b};
                        if ({1'b0, p} + 14'd1 >= total)
                        begin
                            r.section_done = 1'b1;
                            if (!hdr_syntax)
                            begin
                                r.check_status = STATUS_CHECKSUM;
                            end
                            else if (!crc_enable || run_crc == trl_word)
                            begin
                                r.check_status = STATUS_CRC_GOOD;
                            end
                            else
                            begin
                                r.check_status = STATUS_CRC_BAD;
                            end
                            in_section = 1'b0;
                        end
                    end
                end
            endcase
            sec_pos = p + 13'd1;
        end
        // Header fields always show the current header registers.
        r.section_tid        = hdr_table;
        r.mac_address        = hdr_mac;
        r.snap_encap         = hdr_flags[1];
        r.payload_scrambling = hdr_flags[5:4];
        r.address_scrambling = hdr_flags[3:2];
        r.current_next       = hdr_flags[0];
        r.section_index      = hdr_numbers[15:8];
        r.last_section_index = hdr_numbers[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pacing. Most pauses are short, a few are long, and now and then a
    // calm stretch with no pauses at all is started.
    // ------------------------------------------------------------------
    function automatic int draw_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        else if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 98)
        begin
            return $urandom_range(4, 12);
        end
        else
        begin
            return $urandom_range(20, 80);
        end
    endfunction

    function automatic int byte_gap();
        if (calm_bytes > 0)
        begin
            calm_bytes--;
            return 0;
        end
        if ($urandom_range(0, 149) == 0)
        begin
            calm_bytes = $urandom_range(40, 160);
        end
        return draw_pause();
    endfunction

    function automatic int result_gap();
        if (calm_results > 0)
        begin
            calm_results--;
            return 0;
        end
        if ($urandom_range(0, 149) == 0)
        begin
            calm_results = $urandom_range(40, 160);
        end
        return draw_pause();
    endfunction

    // ------------------------------------------------------------------
    // Driver. A transfer on the byte channel is fed to the parser model at
    // the edge where it happens. The next byte is loaded only once the
    // current one has gone, so a stalled byte never changes.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid    <= 1'b0;
            section_byte  <= 8'h00;
            section_start <= 1'b0;
            gap_left      <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                expected_results.push_back(parse_byte(section_byte, section_start));
            end
            if (!byte_valid || !byte_stall)
            begin
                if (gap_left > 0)
                begin
                    byte_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_item      = pending_bytes.pop_front();
                    byte_valid    <= 1'b1;
                    section_byte  <= next_item.value;
                    section_start <= next_item.first;
                    gap_left      <= byte_gap();
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each result transfer is checked against the oldest
    // prediction, and a fresh stall decision is made whenever no stall is left.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        mdsp_result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result transfer with nothing expected, expected none actual data_byte %h",
                     $time, data_byte);
            errors++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("data_valid", 48'(want.data_valid), 48'(data_valid));
            compare_field("data_byte", 48'(want.data_byte), 48'(data_byte));
            compare_field("section_done", 48'(want.section_done), 48'(section_done));
            compare_field("section_tid", 48'(want.section_tid), 48'(section_tid));
            compare_field("mac_address", want.mac_address, mac_address);
            compare_field("snap_encap", 48'(want.snap_encap), 48'(snap_encap));
            compare_field("payload_scrambling", 48'(want.payload_scrambling),
                          48'(payload_scrambling));
            compare_field("address_scrambling", 48'(want.address_scrambling),
                          48'(address_scrambling));
            compare_field("current_next", 48'(want.current_next), 48'(current_next));
            compare_field("section_index", 48'(want.section_index), 48'(section_index));
            compare_field("last_section_index", 48'(want.last_section_index),
                          48'(last_section_index));
            compare_field("check_status", 48'(want.check_status), 48'(check_status));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_result();
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                stall_draw    = result_gap();
                result_stall <= (stall_draw > 0);
                stall_left   <= (stall_draw > 0) ? stall_draw - 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog. Any transfer on either channel restarts the count; a long
    // quiet stretch means the block has hung.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    task automatic push_item(input logic [7:0] value, input logic first);
        byte_item_t item;
        item.value = value;
        item.first = first;
        pending_bytes.push_back(item);
    endtask

    // Queues one section with the given syntax indicator and length field.
    // A cut below the full size truncates the section, which the next start
    // then abandons. A fill of zero or more replaces the random table id,
    // header and payload bytes by that constant. When corrupt is set one
    // bit of the CRC trailer is flipped.
    task automatic add_section(input logic syn, input int len, input int cut,
                               input bit corrupt, input int fill, output int pushed);
        logic [31:0] crc;
        logic [31:0] trailer;
        logic [7:0]  b;
        int          full;
        int          n;
        crc     = CRC_INIT;
        trailer = 32'h0;
        // A short length ends the section right after the length field.
        full    = (len < MIN_SECTION_LEN) ? 3 : len + 3;
        n       = (cut > 0 && cut < full) ? cut : full;
        for (int i = 0; i < n; i++)
        begin
            if (fill >= 0)
            begin
                b = fill[7:0];
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
            end
            if (i == full - 4)
            begin
                trailer = corrupt ? crc ^ (32'h1 << $urandom_range(0, 31)) : crc;
            end
            if (i == 1)
            begin
                b = {syn, b[6:4], len[11:8]};
            end
            else if (i == 2)
            begin
                b = len[7:0];
            end
            else if (i >= 3 && i >= full - 4)
            begin
                b = trailer[31 - 8 * (i - (full - 4)) -: 8];
            end
            if (i < full - 4)
            begin
                crc = crc_step(crc, b);
            end
            push_item(b, i == 0);
        end
        pushed = n;
    endtask

    // Mostly well-formed sections with random content; the rest are bad
    // trailers, short lengths, truncated sections and loose noise bytes.
    task automatic add_random(input int target);
        int   live;
        int   roll;
        int   len;
        int   pushed;
        logic syn;
        logic first;
        live = 0;
        while (live < target)
        begin
            roll = $urandom_range(0, 99);
            syn  = ($urandom_range(0, 4) != 0);
            len  = $urandom_range(0, 99);
            if (len < 75)
            begin
                len = 13 + $urandom_range(0, 30);
            end
            else if (len < 96)
            begin
                len = 13 + $urandom_range(31, 200);
            end
            else
            begin
                len = 13 + $urandom_range(201, 600);
            end
            if (roll < 58)
            begin
                add_section(syn, len, 0, 1'b0, -1, pushed);
            end
            else if (roll < 74)
            begin
                add_section(syn, len, 0, 1'b1, -1, pushed);
            end
            else if (roll < 82)
            begin
                add_section(syn, $urandom_range(0, 12), 0, 1'b0, -1, pushed);
            end
            else if (roll < 92)
            begin
                add_section(syn, len, $urandom_range(1, len + 2), 1'b0, -1, pushed);
            end
            else
            begin
                // Bytes outside a section are ignored by the parser but still
                // give a result; a stray start opens a garbage section that a
                // length error ends or the next start abandons.
                pushed = 0;
                repeat ($urandom_range(1, 4))
                begin
                    first = ($urandom_range(0, 5) == 0);
                    push_item(8'($urandom_range(0, 255)), first);
                    pushed++;
                end
            end
            live += pushed;
        end
    endtask

    // Waits until every queued byte has been taken and every prediction
    // has been matched, then lets the pipeline settle. Polling at the
    // falling edge sees the state after all updates of the rising edge.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access phase meets pready.
    task automatic config_write(input logic [1:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (addr == ADDR_CTRL)
        begin
            crc_enable = value[0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence. Every configuration change happens with the block
    // drained, which also makes the sender wait for all outstanding
    // results between phases.
    // ------------------------------------------------------------------
    initial
    begin
        int pushed;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        config_write(ADDR_CTRL, 32'h1);

        // Directed part. Loose bytes with no section open are ignored.
        push_item(8'hff, 1'b0);
        push_item(8'h00, 1'b0);
        // Length just below the minimum, and a zero length, both end
        // the section at the third byte with a length error.
        add_section(1'b1, 12, 0, 1'b0, 'ha5, pushed);
        push_item(8'h5a, 1'b0);
        add_section(1'b0, 0, 0, 1'b0, 'h00, pushed);
        // Minimum legal length: no payload, header bytes outside the length field all ones, good CRC.
        add_section(1'b1, 13, 0, 1'b0, 'hff, pushed);
        // Largest length field, cut short by the start of the next section.
        add_section(1'b1, 4095, 6, 1'b0, 'hff, pushed);
        add_section(1'b1, 13, 0, 1'b1, -1, pushed);
        wait_drained();

        // CRC check disabled: bad trailers must still report good.
        config_write(ADDR_CTRL, 32'h0);
        add_random(120);
        wait_drained();

        config_write(ADDR_CTRL, 32'h1);
        add_random(260);
        wait_drained();

        config_write(ADDR_CTRL, 32'h0);
        add_random(100);
        wait_drained();

        config_write(ADDR_CTRL, 32'h1);
        add_random(150);
        wait_drained();

        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
